@@ rtl/mcti_pkg.sv @@
package mcti_pkg;

    // Sequencer phases of the card bus master.
    typedef enum logic [4:0] {
        PH_IDLE,
        PH_R_RST,
        PH_R_CKH,
        PH_R_CKL,
        PH_R_SET,
        PH_R_RSL,
        PH_B_BEG,
        PH_B_LOW,
        PH_B_HIGH,
        PH_C_CKH,
        PH_C_START,
        PH_W_LOW,
        PH_W_HIGH,
        PH_P_LOW,
        PH_P_HIGH,
        PH_P_IOH,
        PH_K_LOW,
        PH_K_PH,
        PH_K_PL
    } phase_t;

    localparam logic [1:0] OP_ATR     = 2'd0;
    localparam logic [1:0] OP_COMMAND = 2'd1;
    localparam logic [1:0] OP_READ    = 2'd2;

    // Commands after which the card runs an internal processing cycle.
    localparam logic [7:0] CMD_UPDATE_MAIN     = 8'h38;
    localparam logic [7:0] CMD_WRITE_PROTECT   = 8'h3C;
    localparam logic [7:0] CMD_COMPARE_VERIFY  = 8'h33;
    localparam logic [7:0] CMD_UPDATE_SECURITY = 8'h39;

    localparam logic [31:0] ATR_BLANK = 32'h0000_00FF;

    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_HALF_PERIOD = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SETTLE      = 1'b1;

    localparam logic [7:0]  HALF_PERIOD_RESET = 8'd1;
    localparam logic [15:0] SETTLE_RESET      = 16'd111;

    localparam int QUEUE_DEPTH_DEF = 2;

    typedef struct packed {
        logic [7:0]  half_period_ticks;
        logic [15:0] settle_ticks;
    } mcti_cfg_t;

    // One classified tick as it travels from the front to the sequencer.
    typedef struct packed {
        logic        start;
        logic [1:0]  opcode;
        logic [23:0] shift;
        logic        write_class;
        logic        io;
    } mcti_req_t;

    typedef struct packed {
        logic clk;
        logic rst;
        logic io;
        logic drv;
    } pins_t;

    typedef struct packed {
        pins_t       pins;
        logic        busy;
        logic        byte_valid;
        logic [7:0]  read_byte;
        logic        atr_valid;
        logic [31:0] atr_word;
        logic        atr_ok;
    } mcti_res_t;

endpackage

@@ rtl/memory_card_three_wire_interface.sv @@
// Pin-level bus master for a three-wire memory card. Every request on the input
// channel is one base tick carrying the sampled IO level and, when start_req is
// set while the master is idle, an operation: answer-to-reset, send command, or
// read byte. Each request yields exactly one response with the pin levels to drive
// after that tick plus done flags for a read byte or an answer-to-reset word.
// The master takes one request per clock cycle: the classifying front feeds a
// small queue, and the sequencer behind it advances one tick per cycle into an
// output register, so a stalled output fills the queue before in_ready drops.
// Pin timing is counted in ticks, set by half_period_ticks and settle_ticks;
// write these only while no request is in flight.
module memory_card_three_wire_interface #(
    parameter int QUEUE_DEPTH = mcti_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [mcti_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [mcti_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              start_req,
    input  logic [1:0]                        opcode,
    input  logic [7:0]                        command_byte,
    input  logic [7:0]                        address_byte,
    input  logic [7:0]                        write_data,
    input  logic                              io_in,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              clock_pin,
    output logic                              reset_pin,
    output logic                              io_out,
    output logic                              io_drive,
    output logic                              busy_res,
    output logic                              byte_valid,
    output logic [7:0]                        read_byte,
    output logic                              atr_valid,
    output logic [31:0]                       atr_word,
    output logic                              atr_ok
);
    import mcti_pkg::*;

    logic [7:0]  half_period_ticks_reg;
    logic [15:0] settle_ticks_reg;
    mcti_cfg_t   cfg;
    mcti_req_t   front_req;
    mcti_req_t   q_data;
    logic        q_valid;
    logic        q_pop;
    mcti_res_t   res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_period_ticks_reg <= HALF_PERIOD_RESET;
            settle_ticks_reg      <= SETTLE_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_HALF_PERIOD: half_period_ticks_reg <= cfg_data[7:0];
                CFG_SETTLE:      settle_ticks_reg      <= cfg_data[15:0];
                default:         ;
            endcase
        end
    end

    assign cfg.half_period_ticks = half_period_ticks_reg;
    assign cfg.settle_ticks      = settle_ticks_reg;

    mcti_front u_front (
        .start_req    (start_req),
        .opcode       (opcode),
        .command_byte (command_byte),
        .address_byte (address_byte),
        .write_data   (write_data),
        .io_in        (io_in),
        .req          (front_req)
    );

    mcti_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (in_valid),
        .push_ready (in_ready),
        .push_data  (front_req),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_data   (q_data)
    );

    mcti_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .res       (res)
    );

    assign clock_pin  = res.pins.clk;
    assign reset_pin  = res.pins.rst;
    assign io_out     = res.pins.io;
    assign io_drive   = res.pins.drv;
    assign busy_res   = res.busy;
    assign byte_valid = res.byte_valid;
    assign read_byte  = res.read_byte;
    assign atr_valid  = res.atr_valid;
    assign atr_word   = res.atr_word;
    assign atr_ok     = res.atr_ok;

endmodule

@@ rtl/mcti_front.sv @@
module mcti_front (
    input  logic               start_req,
    input  logic [1:0]         opcode,
    input  logic [7:0]         command_byte,
    input  logic [7:0]         address_byte,
    input  logic [7:0]         write_data,
    input  logic               io_in,
    output mcti_pkg::mcti_req_t req
);
    import mcti_pkg::*;

    // A start with an unknown opcode is cleared here, so the sequencer only starts real operations.
    always_comb
    begin
        req.start       = start_req && (opcode inside {OP_ATR, OP_COMMAND, OP_READ});
        req.opcode      = opcode;
        req.shift       = {write_data, address_byte, command_byte};
        req.write_class = command_byte inside {CMD_UPDATE_MAIN, CMD_WRITE_PROTECT,
                                               CMD_COMPARE_VERIFY, CMD_UPDATE_SECURITY};
        req.io          = io_in;
    end

endmodule

@@ rtl/mcti_queue.sv @@
module mcti_queue #(
    parameter int DEPTH = 2
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push_valid,
    output logic               push_ready,
    input  mcti_pkg::mcti_req_t push_data,
    output logic               pop_valid,
    input  logic               pop,
    output mcti_pkg::mcti_req_t pop_data
);
    import mcti_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    mcti_req_t          entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               do_push;
    logic               do_pop;

    assign push_ready = count_reg != CNT_W'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

@@ rtl/mcti_back.sv @@
module mcti_back (
    input  logic               clk,
    input  logic               rst_n,
    input  mcti_pkg::mcti_cfg_t cfg,
    input  logic               q_valid,
    input  mcti_pkg::mcti_req_t q_data,
    output logic               q_pop,
    output logic               out_valid,
    input  logic               out_ready,
    output mcti_pkg::mcti_res_t res
);
    import mcti_pkg::*;

    typedef struct packed {
        phase_t      ph;
        pins_t       pins;
        logic [15:0] hold;
    } enter_t;

    // Pin levels and hold length of a phase. A zero settle time skips the
    // wait, so the following phase is entered in the same tick.
    function automatic enter_t enter_f(phase_t target, pins_t cur, logic wbit,
                                       logic [15:0] half, logic [15:0] settle);
        enter_t r;
        r.ph   = target;
        r.pins = cur;
        r.hold = half;
        case (target)
            PH_R_RST:
            begin
                r.pins.rst = 1'b1;
                r.pins.clk = 1'b0;
                r.pins.drv = 1'b0;
                r.hold     = settle;
                if (settle == '0)
                begin
                    r.ph       = PH_R_CKH;
                    r.pins.clk = 1'b1;
                    r.hold     = half;
                end
            end
            PH_R_CKH:   r.pins.clk = 1'b1;
            PH_R_CKL:   r.pins.clk = 1'b0;
            PH_R_SET:
            begin
                r.hold = settle;
                if (settle == '0)
                begin
                    r.ph       = PH_R_RSL;
                    r.pins.rst = 1'b0;
                    r.hold     = half;
                end
            end
            PH_R_RSL:   r.pins.rst = 1'b0;
            PH_B_BEG:
            begin
                r.pins.clk = 1'b1;
                r.pins.drv = 1'b0;
            end
            PH_B_LOW:   r.pins.clk = 1'b0;
            PH_B_HIGH:  r.pins.clk = 1'b1;
            PH_C_CKH:   r.pins.clk = 1'b1;
            PH_C_START:
            begin
                r.pins.drv = 1'b1;
                r.pins.io  = 1'b0;
            end
            PH_W_LOW:
            begin
                r.pins.clk = 1'b0;
                r.pins.io  = wbit;
            end
            PH_W_HIGH:  r.pins.clk = 1'b1;
            PH_P_LOW:
            begin
                r.pins.clk = 1'b0;
                r.pins.io  = 1'b0;
            end
            PH_P_HIGH:  r.pins.clk = 1'b1;
            PH_P_IOH:   r.pins.io  = 1'b1;
            PH_K_LOW:
            begin
                r.pins.clk = 1'b0;
                r.pins.drv = 1'b0;
            end
            PH_K_PH:    r.pins.clk = 1'b1;
            PH_K_PL:    r.pins.clk = 1'b0;
            default:
            begin
                r.ph   = PH_IDLE;
                r.hold = '0;
            end
        endcase
        return r;
    endfunction

    phase_t      phase_reg,      phase_next;
    logic        op_read_reg,    op_read_next;
    logic [23:0] shift_reg,      shift_next;
    logic [4:0]  bit_count_reg,  bit_count_next;
    logic [1:0]  byte_index_reg, byte_index_next;
    logic [15:0] hold_reg,       hold_next;
    logic [7:0]  gather_reg,     gather_next;
    logic [31:0] answer_reg,     answer_next;
    logic        np_reg,         np_next;
    pins_t       pins_reg,       pins_next;

    logic        out_valid_reg;
    mcti_res_t   res_reg;
    mcti_res_t   res_next;

    logic        pop;
    logic        go;
    phase_t      target;
    logic        wbit;
    logic        byte_done;
    logic        atr_done;
    logic [7:0]  gather_shift;
    logic [4:0]  bit_inc;
    logic [15:0] half;
    enter_t      ent;

    assign pop       = q_valid && (!out_valid_reg || out_ready);
    assign q_pop     = pop;
    assign out_valid = out_valid_reg;
    assign res       = res_reg;
    assign half      = {8'd0, (cfg.half_period_ticks == '0) ? 8'd1 : cfg.half_period_ticks};

    always_comb
    begin
        phase_next      = phase_reg;
        op_read_next    = op_read_reg;
        shift_next      = shift_reg;
        bit_count_next  = bit_count_reg;
        byte_index_next = byte_index_reg;
        hold_next       = hold_reg;
        gather_next     = gather_reg;
        answer_next     = answer_reg;
        np_next         = np_reg;
        pins_next       = pins_reg;
        go              = 1'b0;
        target          = PH_IDLE;
        wbit            = shift_reg[0];
        byte_done       = 1'b0;
        atr_done        = 1'b0;
        gather_shift    = {q_data.io, gather_reg[7:1]};
        bit_inc         = bit_count_reg + 5'd1;

        if (phase_reg == PH_IDLE)
        begin
            if (q_data.start)
            begin
                op_read_next = q_data.opcode == OP_READ;
                go           = 1'b1;
                case (q_data.opcode)
                    OP_ATR:     target = PH_R_RST;
                    OP_COMMAND:
                    begin
                        shift_next     = q_data.shift;
                        bit_count_next = '0;
                        np_next        = q_data.write_class;
                        target         = PH_C_CKH;
                    end
                    default:    target = PH_B_BEG;
                endcase
            end
        end
        else
        begin
            hold_next = hold_reg - 16'd1;
            if (hold_reg == 16'd1)
            begin
                case (phase_reg)
                    PH_R_RST:   begin go = 1'b1; target = PH_R_CKH; end
                    PH_R_CKH:   begin go = 1'b1; target = PH_R_CKL; end
                    PH_R_CKL:   begin go = 1'b1; target = PH_R_SET; end
                    PH_R_SET:   begin go = 1'b1; target = PH_R_RSL; end
                    PH_R_RSL:
                    begin
                        answer_next     = {31'd0, q_data.io};
                        byte_index_next = '0;
                        go              = 1'b1;
                        target          = PH_B_BEG;
                    end
                    PH_B_BEG:   begin go = 1'b1; target = PH_B_LOW; end
                    PH_B_LOW:   begin go = 1'b1; target = PH_B_HIGH; end
                    PH_B_HIGH:
                    begin
                        gather_next    = gather_shift;
                        bit_count_next = bit_inc;
                        if (bit_inc < 5'd8)
                        begin
                            go     = 1'b1;
                            target = PH_B_LOW;
                        end
                        else if (op_read_reg)
                        begin
                            byte_done  = 1'b1;
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            // Byte i lands at bit i*8+1, above the leading bit.
                            answer_next     = answer_reg
                                            | (32'(gather_shift) << {byte_index_reg, 3'b001});
                            byte_index_next = byte_index_reg + 2'd1;
                            if (byte_index_reg == 2'd3)
                            begin
                                atr_done   = 1'b1;
                                phase_next = PH_IDLE;
                            end
                            else
                            begin
                                go     = 1'b1;
                                target = PH_B_BEG;
                            end
                        end
                    end
                    PH_C_CKH:   begin go = 1'b1; target = PH_C_START; end
                    PH_C_START: begin go = 1'b1; target = PH_W_LOW; end
                    PH_W_LOW:   begin go = 1'b1; target = PH_W_HIGH; end
                    PH_W_HIGH:
                    begin
                        shift_next     = {1'b0, shift_reg[23:1]};
                        bit_count_next = bit_inc;
                        wbit           = shift_reg[1];
                        go             = 1'b1;
                        target         = (bit_inc < 5'd24) ? PH_W_LOW : PH_P_LOW;
                    end
                    PH_P_LOW:   begin go = 1'b1; target = PH_P_HIGH; end
                    PH_P_HIGH:  begin go = 1'b1; target = PH_P_IOH; end
                    PH_P_IOH:
                    begin
                        if (np_reg)
                        begin
                            go     = 1'b1;
                            target = PH_K_LOW;
                        end
                        else
                        begin
                            phase_next = PH_IDLE;
                        end
                    end
                    PH_K_LOW, PH_K_PL:
                    begin
                        // The card signals the end of processing by releasing IO high.
                        if (q_data.io)
                        begin
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            go     = 1'b1;
                            target = PH_K_PH;
                        end
                    end
                    PH_K_PH:    begin go = 1'b1; target = PH_K_PL; end
                    default:    phase_next = PH_IDLE;
                endcase
            end
        end

        ent = enter_f(target, pins_reg, wbit, half, cfg.settle_ticks);
        if (go)
        begin
            phase_next = ent.ph;
            pins_next  = ent.pins;
            hold_next  = ent.hold;
            if (target == PH_B_BEG)
            begin
                bit_count_next = '0;
                gather_next    = '0;
            end
        end

        res_next.pins       = pins_next;
        res_next.busy       = phase_next != PH_IDLE;
        res_next.byte_valid = byte_done;
        res_next.read_byte  = byte_done ? gather_next : 8'd0;
        res_next.atr_valid  = atr_done;
        res_next.atr_word   = atr_done ? answer_next : 32'd0;
        res_next.atr_ok     = atr_done && (answer_next != ATR_BLANK);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            op_read_reg    <= 1'b0;
            shift_reg      <= '0;
            bit_count_reg  <= '0;
            byte_index_reg <= '0;
            hold_reg       <= '0;
            gather_reg     <= '0;
            answer_reg     <= '0;
            np_reg         <= 1'b0;
            pins_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                phase_reg      <= phase_next;
                op_read_reg    <= op_read_next;
                shift_reg      <= shift_next;
                bit_count_reg  <= bit_count_next;
                byte_index_reg <= byte_index_next;
                hold_reg       <= hold_next;
                gather_reg     <= gather_next;
                answer_reg     <= answer_next;
                np_reg         <= np_next;
                pins_reg       <= pins_next;
                out_valid_reg  <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg  <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            res_reg <= res_next;
        end
    end

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import mcti_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 11;
    localparam int DRAIN_CYCLES   = 8;
    localparam int TAIL_CYCLES    = 20;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_GAP        = 18;
    localparam int RANDOM_PHASES  = 3;
    localparam int NUM_ITEMS      = 650;
    localparam int NUM_ROWS       = 8;

    // Opcode value that the master must ignore.
    localparam logic [1:0] OP_NONE = 2'd3;

    typedef enum logic [1:0] { CHK_NONE, CHK_BYTE, CHK_ATR } chk_t;
    typedef enum logic [1:0] { GAP_NONE, GAP_SPARSE, GAP_FULL } gap_t;

    typedef struct packed {
        logic       start;
        logic [1:0] opcode;
        logic [7:0] cmd;
        logic [7:0] addr;
        logic [7:0] wdata;
        logic       io;
    } tick_t;

    typedef struct {
        logic        start;
        logic [1:0]  opcode;
        logic [7:0]  cmd;
        logic [7:0]  addr;
        logic [7:0]  wdata;
        logic [63:0] io_bits;
        logic        io_fill;
        logic        poke;
        logic [7:0]  half;
        logic [15:0] settle;
        chk_t        chk;
        logic [31:0] want;
        logic        want_ok;
    } row_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   in_valid;
    logic                   in_ready;
    logic                   start_req;
    logic [1:0]             opcode;
    logic [7:0]             command_byte;
    logic [7:0]             address_byte;
    logic [7:0]             write_data;
    logic                   io_in;
    logic                   out_valid;
    logic                   out_ready;
    logic                   clock_pin;
    logic                   reset_pin;
    logic                   io_out;
    logic                   io_drive;
    logic                   busy_res;
    logic                   byte_valid;
    logic [7:0]             read_byte;
    logic                   atr_valid;
    logic [31:0]            atr_word;
    logic                   atr_ok;

    memory_card_three_wire_interface DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .start_req    (start_req),
        .opcode       (opcode),
        .command_byte (command_byte),
        .address_byte (address_byte),
        .write_data   (write_data),
        .io_in        (io_in),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .clock_pin    (clock_pin),
        .reset_pin    (reset_pin),
        .io_out       (io_out),
        .io_drive     (io_drive),
        .busy_res     (busy_res),
        .byte_valid   (byte_valid),
        .read_byte    (read_byte),
        .atr_valid    (atr_valid),
        .atr_word     (atr_word),
        .atr_ok       (atr_ok)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Bus sequencer mirror and its register copies.
    logic [7:0]  cfg_half;
    logic [15:0] cfg_settle;
    phase_t      cb_phase;
    logic [1:0]  cb_op;
    logic [23:0] cb_shift;
    logic [4:0]  cb_bits;
    logic [2:0]  cb_byte_idx;
    logic [15:0] cb_wait;
    logic [7:0]  cb_gather;
    logic [31:0] cb_answer;
    logic        cb_process;
    pins_t       card_pins;
    logic        cb_byte_done;
    logic        cb_atr_done;
    logic        cb_sampled;

    mcti_res_t   pin_forecast[$];
    int          mismatches = 0;
    int          quiet_cycles = 0;
    int          items_sent = 0;
    gap_t        gap_style = GAP_SPARSE;
    logic        hold_out = 1'b0;
    logic [63:0] io_seq;
    logic        io_fill;

    row_t plan [NUM_ROWS] = '{
        '{1'b0, OP_ATR, 8'h00, 8'h00, 8'h00, 64'h0, 1'b0, 1'b0, 8'd1, 16'd111,
          CHK_NONE, 32'h0, 1'b0},
        '{1'b1, OP_NONE, 8'hFF, 8'hFF, 8'hFF, 64'h0, 1'b0, 1'b0, 8'd1, 16'd111,
          CHK_NONE, 32'h0, 1'b0},
        '{1'b1, OP_READ, 8'h00, 8'h00, 8'h00, 64'hA5, 1'b0, 1'b1, 8'd1, 16'd111,
          CHK_BYTE, 32'hA5, 1'b0},
        '{1'b1, OP_READ, 8'h00, 8'h00, 8'h00, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0,
          8'd1, 16'd111, CHK_BYTE, 32'hFF, 1'b0},
        '{1'b1, OP_COMMAND, 8'hFF, 8'hFF, 8'hFF, 64'h0, 1'b0, 1'b0, 8'd1, 16'd111,
          CHK_NONE, 32'h0, 1'b0},
        '{1'b1, OP_COMMAND, CMD_UPDATE_MAIN, 8'h55, 8'hAA, 64'h8, 1'b1, 1'b0,
          8'd1, 16'd111, CHK_NONE, 32'h0, 1'b0},
        '{1'b1, OP_ATR, 8'h00, 8'h00, 8'h00, 64'hFF, 1'b0, 1'b1, 8'd0, 16'd0,
          CHK_ATR, ATR_BLANK, 1'b0},
        '{1'b1, OP_ATR, 8'h00, 8'h00, 8'h00, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0,
          8'd0, 16'd0, CHK_ATR, 32'hFFFF_FFFF, 1'b1}
    };

    function automatic void clear_card_bus();
        cfg_half    = HALF_PERIOD_RESET;
        cfg_settle  = SETTLE_RESET;
        cb_phase    = PH_IDLE;
        cb_op       = OP_ATR;
        cb_shift    = '0;
        cb_bits     = '0;
        cb_byte_idx = '0;
        cb_wait     = '0;
        cb_gather   = '0;
        cb_answer   = '0;
        cb_process  = 1'b0;
        card_pins   = '0;
    endfunction

    function automatic void enter_phase(input phase_t p);
        logic [15:0] len;
        len = (cfg_half == 8'd0) ? 16'd1 : {8'd0, cfg_half};
        cb_phase = p;
        case (p)
            PH_R_RST:
            begin
                card_pins.rst = 1'b1;
                card_pins.clk = 1'b0;
                card_pins.drv = 1'b0;
                len = cfg_settle;
            end
            PH_R_SET:   len = cfg_settle;
            PH_R_RSL:   card_pins.rst = 1'b0;
            PH_B_BEG:
            begin
                card_pins.clk = 1'b1;
                card_pins.drv = 1'b0;
                cb_bits = '0;
                cb_gather = '0;
            end
            PH_R_CKL, PH_B_LOW, PH_K_PL:
                card_pins.clk = 1'b0;
            PH_R_CKH, PH_B_HIGH, PH_C_CKH, PH_W_HIGH, PH_P_HIGH, PH_K_PH:
                card_pins.clk = 1'b1;
            PH_C_START:
            begin
                card_pins.drv = 1'b1;
                card_pins.io = 1'b0;
            end
            PH_W_LOW:
            begin
                card_pins.clk = 1'b0;
                card_pins.io = cb_shift[0];
            end
            PH_P_LOW:
            begin
                card_pins.clk = 1'b0;
                card_pins.io = 1'b0;
            end
            PH_P_IOH:   card_pins.io = 1'b1;
            PH_K_LOW:
            begin
                card_pins.clk = 1'b0;
                card_pins.drv = 1'b0;
            end
            default:
            begin
                cb_phase = PH_IDLE;
                len = '0;
            end
        endcase
        cb_wait = len;
    endfunction

    function automatic void close_byte();
        if (cb_op == OP_READ)
        begin
            cb_byte_done = 1'b1;
            cb_phase = PH_IDLE;
        end
        else
        begin
            // The byte lands one bit above its slot; the top byte loses its MSB.
            cb_answer = cb_answer | ({24'd0, cb_gather} << (int'(cb_byte_idx[1:0]) * 8 + 1));
            cb_byte_idx = cb_byte_idx + 3'd1;
            if (cb_byte_idx < 3'd4)
                enter_phase(PH_B_BEG);
            else
            begin
                cb_atr_done = 1'b1;
                cb_phase = PH_IDLE;
            end
        end
    endfunction

    function automatic void finish_phase(input logic io);
        case (cb_phase)
            PH_R_RST:   enter_phase(PH_R_CKH);
            PH_R_CKH:   enter_phase(PH_R_CKL);
            PH_R_CKL:   enter_phase(PH_R_SET);
            PH_R_SET:   enter_phase(PH_R_RSL);
            PH_R_RSL:
            begin
                cb_sampled = 1'b1;
                cb_answer = {31'd0, io};
                cb_byte_idx = '0;
                enter_phase(PH_B_BEG);
            end
            PH_B_BEG:   enter_phase(PH_B_LOW);
            PH_B_LOW:   enter_phase(PH_B_HIGH);
            PH_B_HIGH:
            begin
                cb_sampled = 1'b1;
                cb_gather = {io, cb_gather[7:1]};
                cb_bits = cb_bits + 5'd1;
                if (cb_bits < 5'd8)
                    enter_phase(PH_B_LOW);
                else
                    close_byte();
            end
            PH_C_CKH:   enter_phase(PH_C_START);
            PH_C_START: enter_phase(PH_W_LOW);
            PH_W_LOW:   enter_phase(PH_W_HIGH);
            PH_W_HIGH:
            begin
                cb_shift = cb_shift >> 1;
                cb_bits = cb_bits + 5'd1;
                if (cb_bits < 5'd24)
                    enter_phase(PH_W_LOW);
                else
                    enter_phase(PH_P_LOW);
            end
            PH_P_LOW:   enter_phase(PH_P_HIGH);
            PH_P_HIGH:  enter_phase(PH_P_IOH);
            PH_P_IOH:
            begin
                if (cb_process)
                    enter_phase(PH_K_LOW);
                else
                    cb_phase = PH_IDLE;
            end
            PH_K_LOW, PH_K_PL:
            begin
                // The card signals the end of its processing by releasing IO high.
                cb_sampled = 1'b1;
                if (io)
                    cb_phase = PH_IDLE;
                else
                    enter_phase(PH_K_PH);
            end
            PH_K_PH:    enter_phase(PH_K_PL);
            default:    cb_phase = PH_IDLE;
        endcase
    endfunction

    function automatic mcti_res_t advance_card_bus(input tick_t t);
        mcti_res_t r;
        cb_byte_done = 1'b0;
        cb_atr_done = 1'b0;
        cb_sampled = 1'b0;
        if (cb_phase == PH_IDLE)
        begin
            if (t.start && t.opcode != OP_NONE)
            begin
                cb_op = t.opcode;
                if (t.opcode == OP_ATR)
                    enter_phase(PH_R_RST);
                else if (t.opcode == OP_COMMAND)
                begin
                    cb_shift = {t.wdata, t.addr, t.cmd};
                    cb_bits = '0;
                    cb_process = (t.cmd == CMD_UPDATE_MAIN) || (t.cmd == CMD_WRITE_PROTECT)
                        || (t.cmd == CMD_COMPARE_VERIFY) || (t.cmd == CMD_UPDATE_SECURITY);
                    enter_phase(PH_C_CKH);
                end
                else
                    enter_phase(PH_B_BEG);
            end
        end
        else
        begin
            if (cb_wait != 16'd0)
                cb_wait = cb_wait - 16'd1;
            if (cb_wait == 16'd0)
                finish_phase(t.io);
        end
        // Zero-length settle waits collapse into the tick that reaches them.
        while (cb_phase != PH_IDLE && cb_wait == 16'd0)
            finish_phase(t.io);

        r.pins       = card_pins;
        r.busy       = (cb_phase != PH_IDLE);
        r.byte_valid = cb_byte_done;
        r.read_byte  = cb_byte_done ? cb_gather : 8'd0;
        r.atr_valid  = cb_atr_done;
        r.atr_word   = cb_atr_done ? cb_answer : 32'd0;
        r.atr_ok     = cb_atr_done && (cb_answer != ATR_BLANK);
        return r;
    endfunction

    function automatic int draw_gap();
        case (gap_style)
            GAP_NONE:   return 0;
            GAP_SPARSE: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, MAX_GAP) : 0;
            default:    return $urandom_range(0, MAX_GAP);
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after the request is taken.
    task automatic drive_tick(input tick_t t, input mcti_res_t r);
        int gap;
        gap = draw_gap();
        items_sent++;
        pin_forecast.push_back(r);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid     <= 1'b1;
        start_req    <= t.start;
        opcode       <= t.opcode;
        command_byte <= t.cmd;
        address_byte <= t.addr;
        write_data   <= t.wdata;
        io_in        <= t.io;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    // Feeds one operation tick by tick until the sequencer is predicted idle again.
    task automatic run_op(input tick_t first, input logic chaos, input logic poke,
                          input chk_t chk, input logic [31:0] want, input logic want_ok);
        tick_t     t;
        mcti_res_t r;
        t = first;
        do
        begin
            t.io = chaos ? 1'($urandom_range(0, 1)) : io_seq[0];
            r = advance_card_bus(t);
            if (cb_sampled)
                io_seq = {io_fill, io_seq[63:1]};
            if (chk == CHK_BYTE && r.byte_valid)
                r.read_byte = want[7:0];
            if (chk == CHK_ATR && r.atr_valid)
            begin
                r.atr_word = want;
                r.atr_ok = want_ok;
            end
            drive_tick(t, r);
            if (chaos)
            begin
                t.start  = ($urandom_range(0, 7) == 0);
                t.opcode = 2'($urandom_range(0, 3));
                t.cmd    = 8'($urandom);
                t.addr   = 8'($urandom);
                t.wdata  = 8'($urandom);
            end
            else
                t.start = poke;
        end
        while (cb_phase != PH_IDLE);
    endtask

    task automatic drain_block();
        in_valid <= 1'b0;
        while (pin_forecast.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_regs(input logic [7:0] half, input logic [15:0] settle);
        drain_block();
        cfg_write <= 1'b1;
        cfg_index <= CFG_HALF_PERIOD;
        cfg_data  <= {8'd0, half};
        @(negedge clk);
        cfg_index <= CFG_SETTLE;
        cfg_data  <= settle;
        @(negedge clk);
        cfg_write <= 1'b0;
        cfg_half = half;
        cfg_settle = settle;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %h, actual %h", name, want, got);
            mismatches++;
        end
    endtask

    initial
    begin
        tick_t first;
        int    pick;
        int    rand_start;
        int    phase_end;
        rst_n        = 1'b0;
        cfg_write    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        start_req    = 1'b0;
        opcode       = OP_ATR;
        command_byte = '0;
        address_byte = '0;
        write_data   = '0;
        io_in        = 1'b0;
        clear_card_bus();
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
        begin
            if (plan[i].half != cfg_half || plan[i].settle != cfg_settle)
                write_regs(plan[i].half, plan[i].settle);
            gap_style = (plan[i].half > 8'd8 || plan[i].settle > 16'd1000)
                ? GAP_NONE : GAP_SPARSE;
            io_seq  = plan[i].io_bits;
            io_fill = plan[i].io_fill;
            first = '{plan[i].start, plan[i].opcode, plan[i].cmd, plan[i].addr,
                      plan[i].wdata, 1'b0};
            run_op(first, 1'b0, plan[i].poke, plan[i].chk, plan[i].want, plan[i].want_ok);
        end

        // The random part shares what is left of the item budget evenly between phases.
        rand_start = items_sent;
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            gap_style = gap_t'(p % 3);
            // Wide gaps are paired with short timing so the run stays bounded.
            if (gap_style == GAP_FULL)
                write_regs(8'($urandom_range(0, 1)), 16'($urandom_range(0, 2)));
            else
                write_regs(8'($urandom_range(0, 2)), 16'($urandom_range(0, 6)));
            if (p == 2)
                hold_out = 1'b1;
            phase_end = rand_start + (NUM_ITEMS - rand_start) * (p + 1) / RANDOM_PHASES;
            while (items_sent < phase_end)
            begin
                first.start = 1'b1;
                first.cmd   = 8'($urandom);
                first.addr  = 8'($urandom);
                first.wdata = 8'($urandom);
                first.io    = 1'b0;
                pick = $urandom_range(0, 19);
                if (pick < 4)
                    first.opcode = OP_ATR;
                else if (pick < 12)
                    first.opcode = OP_COMMAND;
                else if (pick < 17)
                    first.opcode = OP_READ;
                else if (pick < 18)
                    first.opcode = OP_NONE;
                else
                begin
                    first.start = 1'b0;
                    first.opcode = 2'($urandom_range(0, 3));
                end
                if (first.opcode == OP_COMMAND && $urandom_range(0, 1) == 1)
                begin
                    case ($urandom_range(0, 3))
                        0:       first.cmd = CMD_UPDATE_MAIN;
                        1:       first.cmd = CMD_WRITE_PROTECT;
                        2:       first.cmd = CMD_COMPARE_VERIFY;
                        default: first.cmd = CMD_UPDATE_SECURITY;
                    endcase
                end
                run_op(first, 1'b1, 1'b0, CHK_NONE, 32'd0, 1'b0);
            end
        end

        in_valid <= 1'b0;
        while (pin_forecast.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

    // Result side: random back-pressure, plus one long hold that fills the block.
    initial
    begin
        int wait_n;
        out_ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_out)
            begin
                wait_n = HOLD_CYCLES;
                hold_out = 1'b0;
            end
            else
                wait_n = draw_gap();
            if (wait_n > 0)
            begin
                out_ready <= 1'b0;
                repeat (wait_n) @(negedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            @(negedge clk);
        end
    end

    always @(posedge clk)
    begin
        mcti_res_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pin_forecast.size() == 0)
            begin
                $error("result with no request pending");
                mismatches++;
            end
            else
            begin
                want = pin_forecast.pop_front();
                check_field("clock_pin", want.pins.clk, clock_pin);
                check_field("reset_pin", want.pins.rst, reset_pin);
                check_field("io_out", want.pins.io, io_out);
                check_field("io_drive", want.pins.drv, io_drive);
                check_field("busy_res", want.busy, busy_res);
                check_field("byte_valid", want.byte_valid, byte_valid);
                check_field("read_byte", want.read_byte, read_byte);
                check_field("atr_valid", want.atr_valid, atr_valid);
                check_field("atr_word", want.atr_word, atr_word);
                check_field("atr_ok", want.atr_ok, atr_ok);
            end
        end
    end

    // Neither channel moving for this long means the block has hung.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("testbench: errors");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

endmodule

@@ files.f @@
rtl/mcti_pkg.sv
rtl/mcti_front.sv
rtl/mcti_queue.sv
rtl/mcti_back.sv
rtl/memory_card_three_wire_interface.sv
verif/testbench.sv
